### sv/pwf_pkg.sv
// Shared types and constants for the prefix word filter.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pwf_pkg;

   // Longest prefix that is compared and buffered.
   localparam int MAX_PREFIX = 16;
   localparam int POS_W      = $clog2(MAX_PREFIX + 1);
   localparam int IDX_W      = $clog2(MAX_PREFIX);
   localparam int HIT_CAP    = 64;
   localparam int HIT_W      = 7;
   localparam int LEN_W      = 5;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LEN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HITS    = 2'd3;

   // Character codes.
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_UC_A  = 8'd65;
   localparam logic [7:0] CHAR_UC_Z  = 8'd90;
   localparam logic [7:0] CASE_DELTA = 8'd32;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_req;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             is_count;
      logic [HIT_W-1:0] hit_count;
      logic             last;
   } rsp_type;

   // Progress of the current line.
   typedef enum logic [1:0] {
      MODE_CMP  = 2'd0,
      MODE_KEEP = 2'd1,
      MODE_SKIP = 2'd2
   } mode_type;

   // Source of the word loaded into the result register.
   typedef enum logic [2:0] {
      SRC_BYTE = 3'd0,
      SRC_BUF  = 3'd1,
      SRC_SEP  = 3'd2,
      SRC_NL   = 3'd3,
      SRC_CNT  = 3'd4
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DECIDE = 3'd1,
      ST_FLUSH  = 3'd2,
      ST_SEP    = 3'd3,
      ST_FIN    = 3'd4,
      ST_FNL    = 3'd5,
      ST_CNT    = 3'd6
   } state_type;

   typedef struct packed {
      logic    capture;
      logic    line_clear;
      logic    set_skip;
      logic    store;
      logic    set_keep;
      logic    flush_start;
      logic    flush_next;
      logic    col_step;
      logic    col_clear;
      logic    hits_clear;
      logic    emit;
      src_type src;
      logic    last;
   } cmd_type;

   typedef struct packed {
      logic     is_brk;
      mode_type mode;
      logic     skip;
      logic     keep;
      logic     fin;
      logic     out_free;
      logic     flush_last;
      logic     col_nz;
   } sts_type;

   // Folds ASCII upper case letters to lower case.
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         r = c + CASE_DELTA;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/pwf_ctrl.sv
// Sequencer for the prefix word filter: walks each text byte through decision,
// prefix flush, separator and end-of-text steps. Uses pwf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwf_ctrl
   import pwf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_type done_st;
      done_st   = sts.fin ? ST_FIN : ST_IDLE;
      state_in  = state_ff;
      cmd       = '0;
      cmd.src   = SRC_BYTE;
      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.is_brk) begin
               if (sts.mode == MODE_KEEP) begin
                  state_in = ST_SEP;
               end else begin
                  cmd.line_clear = 1'b1;
                  state_in       = done_st;
               end
            end else begin
               case (sts.mode)
                  MODE_KEEP: begin
                     if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.src  = SRC_BYTE;
                        cmd.last = !sts.fin;
                        state_in = done_st;
                     end
                  end
                  MODE_CMP: begin
                     if (sts.skip) begin
                        cmd.set_skip = 1'b1;
                        state_in     = done_st;
                     end else begin
                        cmd.store = 1'b1;
                        if (sts.keep) begin
                           cmd.set_keep    = 1'b1;
                           cmd.flush_start = 1'b1;
                           state_in        = ST_FLUSH;
                        end else begin
                           state_in = done_st;
                        end
                     end
                  end
                  default: begin
                     state_in = done_st;
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.src        = SRC_BUF;
               cmd.last       = sts.flush_last && !sts.fin;
               cmd.flush_next = 1'b1;
               if (sts.flush_last) begin
                  state_in = done_st;
               end
            end
         end
         ST_SEP: begin
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.src        = SRC_SEP;
               cmd.last       = !sts.fin;
               cmd.col_step   = 1'b1;
               cmd.line_clear = 1'b1;
               state_in       = done_st;
            end
         end
         ST_FIN: begin
            if (sts.mode == MODE_KEEP) begin
               if (sts.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.src        = SRC_SEP;
                  cmd.col_step   = 1'b1;
                  cmd.line_clear = 1'b1;
                  state_in       = ST_FNL;
               end
            end else begin
               cmd.line_clear = 1'b1;
               state_in       = ST_FNL;
            end
         end
         ST_FNL: begin
            if (sts.col_nz) begin
               if (sts.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.src       = SRC_NL;
                  cmd.col_clear = 1'b1;
                  state_in      = ST_CNT;
               end
            end else begin
               state_in = ST_CNT;
            end
         end
         ST_CNT: begin
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.src        = SRC_CNT;
               cmd.last       = 1'b1;
               cmd.hits_clear = 1'b1;
               cmd.col_clear  = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/pwf_dpath.sv
// Datapath for the prefix word filter: configuration registers, line state,
// prefix buffer, row and hit counters and the result register. Uses pwf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwf_dpath
   import pwf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire req_type              req_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data
);

   logic [CSR_W-1:0] prefix_low_ff;
   logic [CSR_W-1:0] prefix_high_ff;
   logic [LEN_W-1:0] prefix_len_ff;
   logic [HIT_W-1:0] max_hits_ff;

   logic [7:0]       byte_ff;
   logic             fin_ff;
   logic [7:0]       line_buf_ff [MAX_PREFIX];
   logic [POS_W-1:0] pos_ff,  pos_in;
   mode_type         mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff,  idx_in;
   logic [1:0]       col_ff,  col_in;
   logic [HIT_W-1:0] hits_ff, hits_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff,  rsp_data_in;

   logic [POS_W-1:0] plen;
   logic [HIT_W-1:0] hmax;
   logic [7:0]       pchar;
   logic [POS_W-1:0] pos_next;
   logic             mismatch;
   logic [7:0]       sep_byte;

   // Effective prefix length and hit limit after clamping.
   always_comb begin
      if (prefix_len_ff == '0) begin
         plen = POS_W'(1);
      end else if (prefix_len_ff > LEN_W'(MAX_PREFIX)) begin
         plen = POS_W'(MAX_PREFIX);
      end else begin
         plen = POS_W'(prefix_len_ff);
      end
      hmax = (max_hits_ff > HIT_W'(HIT_CAP)) ? HIT_W'(HIT_CAP) : max_hits_ff;
   end

   always_comb begin
      logic [2*CSR_W-1:0] pvec;
      pvec  = {prefix_high_ff, prefix_low_ff};
      pchar = '0;
      if (pos_ff < POS_W'(MAX_PREFIX)) begin
         pchar = pvec[8*pos_ff[IDX_W-1:0] +: 8];
      end
   end

   assign pos_next = (pos_ff < POS_W'(MAX_PREFIX)) ? pos_ff + POS_W'(1) : pos_ff;
   assign mismatch = (pos_ff < plen) && (fold_case(byte_ff) != fold_case(pchar));
   assign sep_byte = (col_ff == 2'd3) ? CHAR_LF : CHAR_TAB;

   always_comb begin
      sts.is_brk     = (byte_ff == CHAR_LF) || (byte_ff == CHAR_CR);
      sts.mode       = mode_ff;
      sts.skip       = ((pos_ff == '0) && (hits_ff >= hmax)) || mismatch;
      sts.keep       = (pos_next >= plen);
      sts.fin        = fin_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
      sts.flush_last = ((POS_W'(idx_ff) + POS_W'(1)) == pos_ff);
      sts.col_nz     = (col_ff != 2'd0);
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_low_ff  <= '0;
         prefix_high_ff <= '0;
         prefix_len_ff  <= LEN_W'(1);
         max_hits_ff    <= HIT_W'(HIT_CAP);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PREFIX_LOW:  prefix_low_ff  <= csr_wdata;
            CSR_PREFIX_HIGH: prefix_high_ff <= csr_wdata;
            CSR_PREFIX_LEN:  prefix_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_MAX_HITS:    max_hits_ff    <= csr_wdata[HIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Line, row and hit state.
   always_comb begin
      pos_in  = pos_ff;
      mode_in = mode_ff;
      idx_in  = idx_ff;
      col_in  = col_ff;
      hits_in = hits_ff;
      if (cmd.line_clear) begin
         pos_in  = '0;
         mode_in = MODE_CMP;
      end
      if (cmd.set_skip) begin
         mode_in = MODE_SKIP;
      end
      if (cmd.store) begin
         pos_in = pos_next;
      end
      if (cmd.set_keep) begin
         mode_in = MODE_KEEP;
      end
      if (cmd.flush_start) begin
         idx_in = '0;
      end else if (cmd.flush_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.col_step) begin
         col_in = col_ff + 2'd1;
         if (hits_ff != '1) begin
            hits_in = hits_ff + HIT_W'(1);
         end
      end
      if (cmd.col_clear) begin
         col_in = '0;
      end
      if (cmd.hits_clear) begin
         hits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mode_ff <= MODE_CMP;
         idx_ff  <= '0;
         col_ff  <= '0;
         hits_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         mode_ff <= mode_in;
         idx_ff  <= idx_in;
         col_ff  <= col_in;
         hits_ff <= hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_data.text_byte;
         fin_ff  <= req_data.final_req;
      end
      if (cmd.store && (pos_ff < POS_W'(MAX_PREFIX))) begin
         line_buf_ff[pos_ff[IDX_W-1:0]] <= byte_ff;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.is_count  = 1'b0;
         rsp_data_in.hit_count = '0;
         rsp_data_in.last      = cmd.last;
         case (cmd.src)
            SRC_BYTE: rsp_data_in.out_byte = byte_ff;
            SRC_BUF:  rsp_data_in.out_byte = line_buf_ff[idx_ff];
            SRC_SEP:  rsp_data_in.out_byte = sep_byte;
            SRC_NL:   rsp_data_in.out_byte = CHAR_LF;
            SRC_CNT: begin
               rsp_data_in.out_byte  = '0;
               rsp_data_in.is_count  = 1'b1;
               rsp_data_in.hit_count = hits_ff;
            end
            default:  rsp_data_in.out_byte = byte_ff;
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### sv/prefix_word_filter.sv
// Top level of the prefix word filter: joins the sequencer and the datapath.
// Depends on pwf_pkg, pwf_ctrl and pwf_dpath.
//
//   Port group  Dir  Handshake            Word
//   req_*       in   req_valid/req_stall  req_type: text_byte, final_req
//   rsp_*       out  rsp_valid/rsp_stall  rsp_type: out_byte, is_count, hit_count, last
//   csr_*       in   csr_we               csr_index selects a register, csr_wdata
//
// A text byte is accepted in the idle state and decided in the decide state,
// which also loads an echoed byte into the result register. A byte that
// completes a matching prefix then flushes the line buffer, one buffered
// character (up to 16) per word, and a line break of a kept line adds a step
// for its tab or newline. The final byte adds the closing separator, newline
// and count steps, whether or not a step loads a word.
// Reset is synchronous and returns all line, row and hit state and the
// registers to their defaults. A stall on the result side holds the result
// register and freezes the sequencer wherever it waits to load the next word;
// the input side is stalled whenever a byte is in work.
`timescale 1ns / 1ps
`default_nettype none

module prefix_word_filter
   import pwf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // Commands flow from the sequencer to the datapath and status flows back.
   cmd_type cmd;
   sts_type sts;

   // The sequencer owns the input handshake and steps through the results
   // that one byte causes.
   pwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the data, line, row and hit state and the result register, so a
   // finished word can wait on the output while the next byte is taken.
   pwf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sv/pwf_checker.sv
// Port-level checks for the prefix word filter and the bind that attaches
// them to the top level. Uses pwf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwf_checker
   import pwf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A held result word must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Every byte is decided before another one is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second byte taken before the first was decided");

   // The count closes the results of the final byte and is clean.
   a_count_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_count |->
         rsp_data.last && (rsp_data.out_byte == 8'd0) &&
         (rsp_data.hit_count <= HIT_W'(HIT_CAP)))
      else $error("malformed count word");

   // A byte word has a zero hit count, and a line break in the text is never echoed as CR.
   a_byte_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_count |->
         (rsp_data.hit_count == '0) && (rsp_data.out_byte != CHAR_CR))
      else $error("malformed byte word");

endmodule

bind prefix_word_filter pwf_checker u_pwf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### test/tb_prefix_word_filter.sv
`timescale 1ns / 1ps
// Self-checking bench for prefix_word_filter: streams text lines and register
// writes, predicts every echoed word and hit count, and checks each result.
// Depends on pwf_pkg and the prefix_word_filter RTL.

module tb_prefix_word_filter;
   import pwf_pkg::*;

   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE      = 40;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PREFIX_LOW;
   logic [CSR_W-1:0]     csr_wdata = '0;

   prefix_word_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow copy of the registers and of the line, row and hit state.
   logic [63:0]      pfx_lo;
   logic [63:0]      pfx_hi;
   logic [LEN_W-1:0] pfx_len;
   logic [HIT_W-1:0] hit_limit;
   logic [7:0]       held_chars [MAX_PREFIX];
   int unsigned      held_n;
   mode_type         line_state;
   logic [1:0]       row_col;
   logic [HIT_W-1:0] kept_words;

   // Result words still owed by the block, oldest first.
   rsp_type echo_words[$];

   int unsigned fail_count = 0;
   int unsigned gap_pct    = 0;
   int unsigned stall_pct  = 0;
   int unsigned stall_left = 0;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         return c + CASE_DELTA;
      end
      return c;
   endfunction

   function automatic logic [7:0] prefix_at(input int unsigned i);
      if (i < 8) begin
         return pfx_lo[8*i +: 8];
      end
      if (i < 16) begin
         return pfx_hi[8*(i-8) +: 8];
      end
      return 8'h00;
   endfunction

   // Length zero compares one character; anything past the buffer is capped.
   function automatic int unsigned match_len();
      if (pfx_len == 0) begin
         return 1;
      end
      if (pfx_len > MAX_PREFIX) begin
         return MAX_PREFIX;
      end
      return pfx_len;
   endfunction

   function automatic int unsigned hit_ceiling();
      return (hit_limit > HIT_CAP) ? HIT_CAP : hit_limit;
   endfunction

   function automatic void clear_filter();
      pfx_lo     = '0;
      pfx_hi     = '0;
      pfx_len    = LEN_W'(1);
      hit_limit  = HIT_W'(HIT_CAP);
      held_n     = 0;
      line_state = MODE_CMP;
      row_col    = '0;
      kept_words = '0;
      foreach (held_chars[i]) held_chars[i] = 8'h00;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_W-1:0] val);
      case (idx)
         CSR_PREFIX_LOW:  pfx_lo    = val;
         CSR_PREFIX_HIGH: pfx_hi    = val;
         CSR_PREFIX_LEN:  pfx_len   = val[LEN_W-1:0];
         CSR_MAX_HITS:    hit_limit = val[HIT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void push_word(input logic [7:0] b, input logic is_cnt,
                                     input logic [HIT_W-1:0] cnt);
      rsp_type w;
      w.out_byte  = b;
      w.is_count  = is_cnt;
      w.hit_count = cnt;
      w.last      = 1'b0;
      echo_words.push_back(w);
   endfunction

   // A kept line closes with a tab, or with a newline when it is the fourth of its row.
   function automatic void close_line();
      if (line_state == MODE_KEEP) begin
         if (row_col == 2'd3) begin
            push_word(CHAR_LF, 1'b0, '0);
            row_col = '0;
         end else begin
            push_word(CHAR_TAB, 1'b0, '0);
            row_col++;
         end
         if (kept_words != '1) begin
            kept_words++;
         end
      end
      held_n     = 0;
      line_state = MODE_CMP;
   endfunction

   // Works out the result words that one text byte causes, in order.
   function automatic void filter_byte(input logic [7:0] c, input logic fin);
      int unsigned start;
      int unsigned plen;
      rsp_type     tail;
      start = echo_words.size();
      if (c == CHAR_LF || c == CHAR_CR) begin
         close_line();
      end else if (line_state == MODE_KEEP) begin
         push_word(c, 1'b0, '0);
      end else if (line_state == MODE_CMP) begin
         plen = match_len();
         if (held_n == 0 && kept_words >= hit_ceiling()) begin
            line_state = MODE_SKIP;
         end else if (held_n < plen && lower_ascii(c) != lower_ascii(prefix_at(held_n))) begin
            line_state = MODE_SKIP;
         end else begin
            if (held_n < MAX_PREFIX) begin
               held_chars[held_n] = c;
               held_n++;
            end
            // Once enough characters match, the held start of the line goes out.
            if (held_n >= plen) begin
               for (int i = 0; i < held_n; i++) push_word(held_chars[i], 1'b0, '0);
               line_state = MODE_KEEP;
            end
         end
      end
      if (fin) begin
         close_line();
         if (row_col != 0) begin
            push_word(CHAR_LF, 1'b0, '0);
         end
         push_word(8'h00, 1'b1, kept_words);
         row_col    = '0;
         kept_words = '0;
      end
      if (echo_words.size() > start) begin
         tail = echo_words.pop_back();
         tail.last = 1'b1;
         echo_words.push_back(tail);
      end
   endfunction

   // Sends one text byte and returns at the edge where the block takes it.
   task automatic send_byte(input logic [7:0] c, input logic fin);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      filter_byte(c, fin);
      req_data  <= '{text_byte: c, final_req: fin};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Registers may only change while the block is idle, so every owed word is
   // collected first and then the sequencer gets time to finish silent bytes.
   task automatic settle_block();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (echo_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (echo_words.size() != 0) begin
         report_mismatch($sformatf("%0d result words never arrived", echo_words.size()));
         echo_words.delete();
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_register(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
      end
   endtask

   // Every result word taken by the bench is held against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (echo_words.size() == 0) begin
            report_mismatch($sformatf("result word %h with none predicted", rsp_data));
         end else begin
            want = echo_words.pop_front();
            check_field("out_byte", rsp_data.out_byte, want.out_byte);
            check_field("is_count", 8'(rsp_data.is_count), 8'(want.is_count));
            check_field("hit_count", 8'(rsp_data.hit_count), 8'(want.hit_count));
            check_field("last", 8'(rsp_data.last), 8'(want.last));
         end
      end
   end

   // Random result side back-pressure in bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [7:0] break_char();
      return $urandom_range(1) ? CHAR_LF : CHAR_CR;
   endfunction

   // Any byte that does not end a line.
   function automatic logic [7:0] word_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      if (c == CHAR_LF || c == CHAR_CR) begin
         c = c + 8'd1;
      end
      return c;
   endfunction

   function automatic logic [7:0] mixed_case(input logic [7:0] c);
      logic [7:0] low;
      low = lower_ascii(c);
      if (low >= "a" && low <= "z" && $urandom_range(1) == 1) begin
         return low - CASE_DELTA;
      end
      return low;
   endfunction

   function automatic void random_prefix(output logic [63:0] lo, output logic [63:0] hi);
      logic [7:0] c;
      lo = '0;
      hi = '0;
      for (int i = 0; i < MAX_PREFIX; i++) begin
         c = ($urandom_range(3) == 0) ? word_char() : mixed_case(8'("a" + $urandom_range(25)));
         if (i < 8) begin
            lo[8*i +: 8] = c;
         end else begin
            hi[8*(i-8) +: 8] = c;
         end
      end
   endfunction

   // One line of text: mostly the prefix in random case plus a word body, else
   // a line that stops early or strays from the prefix, else raw noise.
   task automatic send_line(output int unsigned sent);
      logic [7:0]  text[$];
      int unsigned plen;
      int unsigned cut;
      int unsigned fin_at;
      int unsigned pick;
      plen = match_len();
      pick = $urandom_range(99);
      if (pick < 60) begin
         for (int unsigned i = 0; i < plen; i++) text.push_back(mixed_case(prefix_at(i)));
         repeat ($urandom_range(5)) text.push_back(word_char());
      end else if (pick < 85) begin
         cut = $urandom_range(plen - 1);
         for (int unsigned i = 0; i < cut; i++) text.push_back(mixed_case(prefix_at(i)));
         if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 4)) text.push_back(word_char());
         end
      end else begin
         repeat ($urandom_range(1, 8)) begin
            text.push_back(($urandom_range(6) == 0) ? break_char() : word_char());
         end
      end
      repeat ($urandom_range(1, 3)) text.push_back(break_char());
      // Now and then the text ends inside the line or on one of its breaks.
      fin_at = ($urandom_range(99) < 4) ? $urandom_range(text.size() - 1) : text.size();
      foreach (text[i]) send_byte(text[i], i == fin_at);
      sent = text.size();
   endtask

   task automatic run_phase(input logic [LEN_W-1:0] len, input logic [HIT_W-1:0] limit,
                            input int unsigned items);
      logic [63:0] lo;
      logic [63:0] hi;
      int unsigned sent;
      int unsigned done;
      settle_block();
      random_prefix(lo, hi);
      set_register(CSR_PREFIX_LOW, lo);
      set_register(CSR_PREFIX_HIGH, hi);
      set_register(CSR_PREFIX_LEN, CSR_W'(len));
      set_register(CSR_MAX_HITS, CSR_W'(limit));
      done = 0;
      while (done < items) begin
         send_line(sent);
         done += sent;
         if ($urandom_range(99) < 4) begin
            settle_block();
            if ($urandom_range(1) == 1) begin
               set_register(CSR_PREFIX_LEN, CSR_W'($urandom_range(31)));
            end else begin
               set_register(CSR_MAX_HITS, CSR_W'($urandom_range(127)));
            end
         end
      end
      send_byte(($urandom_range(1) == 1) ? break_char() : word_char(), 1'b1);
      settle_block();
   endtask

   // Reset registers give a one character prefix of NUL. Byte extremes are
   // echoed, a plain letter is skipped and the final byte closes the row.
   task automatic test_reset_defaults();
      gap_pct   = 20;
      stall_pct = 20;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte("A", 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte("a", 1'b1);
      settle_block();
   endtask

   // Length zero compares one character without regard to case; a hit limit of
   // zero keeps nothing, and a limit of one stops after the first kept word.
   task automatic test_case_fold_and_limits();
      set_register(CSR_PREFIX_LOW, 64'h71);
      set_register(CSR_PREFIX_HIGH, '0);
      set_register(CSR_PREFIX_LEN, CSR_W'(0));
      set_register(CSR_MAX_HITS, CSR_W'(0));
      send_byte("Q", 1'b0);
      send_byte(CHAR_LF, 1'b0);
      settle_block();
      set_register(CSR_MAX_HITS, CSR_W'(1));
      send_byte("Q", 1'b0);
      send_byte("Z", 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte("q", 1'b1);
      settle_block();
   endtask

   // Prefix "abc": a short line and a break run, then a length lowered while a
   // line is still being compared, then a hit limit lowered under a kept line.
   task automatic test_short_and_midline_changes();
      set_register(CSR_PREFIX_LOW, 64'h0000_0000_0063_6261);
      set_register(CSR_PREFIX_LEN, CSR_W'(3));
      set_register(CSR_MAX_HITS, CSR_W'(2));
      send_byte("A", 1'b0);
      send_byte("b", 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte("a", 1'b0);
      send_byte("B", 1'b0);
      settle_block();
      set_register(CSR_PREFIX_LEN, CSR_W'(2));
      send_byte("x", 1'b0);
      settle_block();
      set_register(CSR_MAX_HITS, CSR_W'(1));
      send_byte("y", 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte("a", 1'b0);
      send_byte("b", 1'b0);
      send_byte("c", 1'b0);
      send_byte(CHAR_LF, 1'b1);
      settle_block();
   endtask

   // Full sixteen character prefixes, once exact and once past the buffer size.
   task automatic test_long_prefix();
      gap_pct   = 25;
      stall_pct = 25;
      run_phase(LEN_W'(16), HIT_W'(127), 35);
      run_phase(LEN_W'(31), HIT_W'(HIT_CAP), 30);
   endtask

   task automatic test_hit_limit();
      gap_pct   = 10;
      stall_pct = 40;
      run_phase(LEN_W'(1), HIT_W'(1), 25);
      run_phase(LEN_W'(3), HIT_W'(5), 30);
      run_phase(LEN_W'(0), HIT_W'(HIT_CAP), 30);
   endtask

   task automatic test_random_text();
      repeat (3) begin
         gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 35);
         stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 35);
         run_phase(LEN_W'($urandom_range(31)), HIT_W'($urandom_range(127)), 30);
      end
   endtask

   task automatic test_without_idling();
      gap_pct   = 0;
      stall_pct = 0;
      run_phase(LEN_W'(2), HIT_W'(65), 40);
   endtask

   initial begin
      clear_filter();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_reset_defaults();
      test_case_fold_and_limits();
      test_short_and_midline_changes();
      test_long_prefix();
      test_hit_limit();
      test_random_text();
      test_without_idling();
      settle_block();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
